// File: hdl/vlt_pkg.sv
// ----------------------------------------------------------------------------
// vlt_pkg
// Shared types and constants of the voxel line traversal unit.
// ----------------------------------------------------------------------------
package vlt_pkg;

	localparam int CELL_W       = 10;
	localparam int COORD_BITS   = 10;
	localparam int MAX_STEPS    = 63;
	localparam int QUEUE_DEPTH  = 2;
	localparam int NUM_AXES     = 3;

	typedef struct packed {
		logic [CELL_W-1:0] start_x;
		logic [CELL_W-1:0] start_y;
		logic [CELL_W-1:0] start_z;
		logic [CELL_W-1:0] end_x;
		logic [CELL_W-1:0] end_y;
		logic [CELL_W-1:0] end_z;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [CELL_W-1:0] cell_z;
		logic              last;
		logic              too_long;
	} result_t;

endpackage

// File: hdl/vlt_front.sv
// ----------------------------------------------------------------------------
// vlt_front
// Classifies a line request: per-axis span and direction, span limit check.
// ----------------------------------------------------------------------------
module vlt_front #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS,
	parameter int MAX_STEPS  = vlt_pkg::MAX_STEPS,
	localparam int CW        = COORD_BITS,
	localparam int SW        = $clog2(MAX_STEPS + 1),
	localparam int ENTRY_W   = 4 + 3 * SW + 3 * CW
) (
	input  vlt_pkg::cmd_t       cmd,
	output logic [ENTRY_W-1:0]  entry
);

	logic [CW-1:0]   s [3];
	logic [CW-1:0]   e [3];
	logic [CW-1:0]   d [3];
	logic [2:0]      up;
	logic [CW+1:0]   total;
	logic            too_long;

	assign s[0] = CW'(cmd.start_x);
	assign s[1] = CW'(cmd.start_y);
	assign s[2] = CW'(cmd.start_z);
	assign e[0] = CW'(cmd.end_x);
	assign e[1] = CW'(cmd.end_y);
	assign e[2] = CW'(cmd.end_z);

	always_comb begin
		total = '0;
		for (int i = 0; i < 3; i++) begin
			up[i] = (e[i] >= s[i]);
			d[i]  = up[i] ? (e[i] - s[i]) : (s[i] - e[i]);
			total = total + (CW + 2)'(d[i]);
		end
		too_long = (total > (CW + 2)'(MAX_STEPS));
	end

	// spans fit in SW bits whenever the line is within the limit
	assign entry = {too_long, up, SW'(d[2]), SW'(d[1]), SW'(d[0]), s[2], s[1], s[0]};

endmodule

// File: hdl/vlt_queue.sv
// ----------------------------------------------------------------------------
// vlt_queue
// Short FIFO between the classifying front and the walking back end.
// ----------------------------------------------------------------------------
module vlt_queue #(
	parameter int W     = 8,
	parameter int DEPTH = vlt_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  wdata,
	input  logic          pop,
	output logic [W-1:0]  rdata,
	output logic          full,
	output logic          empty
);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: hdl/vlt_back.sv
// ----------------------------------------------------------------------------
// vlt_back
// Walks one classified line, one voxel per cycle, using exact crossing-time
// comparison by cross products.
// ----------------------------------------------------------------------------
module vlt_back #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS,
	parameter int MAX_STEPS  = vlt_pkg::MAX_STEPS,
	localparam int CW        = COORD_BITS,
	localparam int SW        = $clog2(MAX_STEPS + 1),
	localparam int PW        = 2 * SW + 1,
	localparam int ENTRY_W   = 4 + 3 * SW + 3 * CW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  logic [ENTRY_W-1:0]   entry,
	output logic                 pop,
	output logic                 strobe,
	output vlt_pkg::result_t     result
);

	logic               run_q;
	logic [CW-1:0]      cur_q  [3];
	logic [SW-1:0]      span_q [3];
	logic [SW-1:0]      done_q [3];
	logic [2:0]         up_q;
	logic               strobe_q;
	vlt_pkg::result_t   out_q;

	// entry fields
	logic [CW-1:0]      e_cur  [3];
	logic [SW-1:0]      e_span [3];
	logic [2:0]         e_up;
	logic               e_too_long;
	logic               e_zero;

	// walk step
	logic [2:0]         act;
	logic [2:0]         step;
	logic [SW:0]        t      [3];
	logic [SW-1:0]      nxt_done [3];
	logic [CW-1:0]      nxt_cur  [3];
	logic               at_end;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_cur[i]  = entry[i*CW +: CW];
			e_span[i] = entry[3*CW + i*SW +: SW];
		end
		e_up       = entry[3*CW + 3*SW +: 3];
		e_too_long = entry[ENTRY_W-1];
		e_zero     = (e_span[0] == '0) && (e_span[1] == '0) && (e_span[2] == '0);
	end

	assign pop = !empty && !run_q;

	// axis i crosses next at t_i/(2*a_i); it steps if no active axis is earlier
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			act[i] = (done_q[i] < span_q[i]);
			t[i]   = {done_q[i], 1'b1};
		end
		at_end = 1'b1;
		for (int i = 0; i < 3; i++) begin
			step[i] = act[i];
			for (int j = 0; j < 3; j++) begin
				if (j != i && act[j] &&
				    (PW'(t[i]) * PW'(span_q[j]) > PW'(t[j]) * PW'(span_q[i])))
					step[i] = 1'b0;
			end
			nxt_done[i] = done_q[i] + SW'(step[i]);
			if (!step[i])
				nxt_cur[i] = cur_q[i];
			else if (up_q[i])
				nxt_cur[i] = cur_q[i] + 1'b1;
			else
				nxt_cur[i] = cur_q[i] - 1'b1;
			at_end = at_end && (nxt_done[i] >= span_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= pop || run_q;
			if (pop)
				run_q <= !(e_too_long || e_zero);
			else if (run_q)
				run_q <= !at_end;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 3; i++) begin
				cur_q[i]  <= e_cur[i];
				span_q[i] <= e_span[i];
				done_q[i] <= '0;
			end
			up_q <= e_up;
			out_q.cell_x   <= e_too_long ? '0 : vlt_pkg::CELL_W'(e_cur[0]);
			out_q.cell_y   <= e_too_long ? '0 : vlt_pkg::CELL_W'(e_cur[1]);
			out_q.cell_z   <= e_too_long ? '0 : vlt_pkg::CELL_W'(e_cur[2]);
			out_q.last     <= e_too_long || e_zero;
			out_q.too_long <= e_too_long;
		end else if (run_q) begin
			for (int i = 0; i < 3; i++) begin
				cur_q[i]  <= nxt_cur[i];
				done_q[i] <= nxt_done[i];
			end
			out_q.cell_x   <= vlt_pkg::CELL_W'(nxt_cur[0]);
			out_q.cell_y   <= vlt_pkg::CELL_W'(nxt_cur[1]);
			out_q.cell_z   <= vlt_pkg::CELL_W'(nxt_cur[2]);
			out_q.last     <= at_end;
			out_q.too_long <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign result = out_q;

endmodule

// File: hdl/voxel_line_traversal_unit.sv
// ----------------------------------------------------------------------------
// voxel_line_traversal_unit
// Emits every voxel crossed by a within-limit segment between voxel centers.
// ----------------------------------------------------------------------------
// With the queue and walk idle, an accepted request is written into the queue,
// popped by the walk, and its first result is registered in strobe_q/out_q.
// A line of summed span n gives up to n+1 results (at most 64), fewer on ties,
// on consecutive cycles; the next queued line pops during the last result, so
// lines follow with no gap. Equal-endpoint or too-long lines give one result.
// busy rises when the two-entry request queue is full. Results cannot stall.
// Reset: asynchronous, clears queue pointers and walk control; no results.
module voxel_line_traversal_unit #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS,
	parameter int MAX_STEPS  = vlt_pkg::MAX_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vlt_pkg::cmd_t      cmd,
	output logic               strobe,
	output vlt_pkg::result_t   result
);

	localparam int SW      = $clog2(MAX_STEPS + 1);
	localparam int ENTRY_W = 4 + 3 * SW + 3 * COORD_BITS;

	logic [ENTRY_W-1:0] f_entry;
	logic [ENTRY_W-1:0] q_entry;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic               push;

	// request beat
	assign push = start && !q_full;
	assign busy = q_full;

	vlt_front #(
		.COORD_BITS (COORD_BITS),
		.MAX_STEPS  (MAX_STEPS)
	) u_front (
		.cmd   (cmd),
		.entry (f_entry)
	);

	vlt_queue #(
		.W     (ENTRY_W),
		.DEPTH (vlt_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_entry),
		.pop    (q_pop),
		.rdata  (q_entry),
		.full   (q_full),
		.empty  (q_empty)
	);

	vlt_back #(
		.COORD_BITS (COORD_BITS),
		.MAX_STEPS  (MAX_STEPS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.entry  (q_entry),
		.pop    (q_pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for voxel_line_traversal_unit. Line requests are sent
// through the start/busy handshake, and every accepted request is walked by
// an exact integer model of the voxel traversal. Each strobed cell is
// checked against the oldest predicted cell, field by field.
// ----------------------------------------------------------------------------
module testbench;

	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_CELLS   = 64;
	localparam int MAX_PRINTS  = 30;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	vlt_pkg::cmd_t     cmd;
	logic              strobe;
	vlt_pkg::result_t  result;

	vlt_pkg::result_t predicted_cells[$];
	int               lines_sent;
	int               cells_checked;
	int               errors;
	int               quiet_cycles;

	voxel_line_traversal_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic void queue_cell(input vlt_pkg::result_t r);
		predicted_cells = {predicted_cells, r};
	endfunction

	// Exact traversal: axis crossings at (2n+1)/(2a), ties step together
	function automatic void walk_line(input vlt_pkg::cmd_t c);
		int unsigned      pos[3];
		int unsigned      fin[3];
		int unsigned      span[3];
		int unsigned      done[3];
		bit               up[3];
		bit               hit[3];
		int unsigned      total;
		int               lead;
		int               emitted;
		bit               at_end;
		vlt_pkg::result_t r;
		int unsigned      mask;
		mask = (1 << vlt_pkg::COORD_BITS) - 1;
		pos[0] = c.start_x & mask;
		pos[1] = c.start_y & mask;
		pos[2] = c.start_z & mask;
		fin[0] = c.end_x & mask;
		fin[1] = c.end_y & mask;
		fin[2] = c.end_z & mask;
		total = 0;
		for (int i = 0; i < 3; i++) begin
			up[i] = fin[i] >= pos[i];
			span[i] = up[i] ? fin[i] - pos[i] : pos[i] - fin[i];
			done[i] = 0;
			total += span[i];
		end
		if (total > vlt_pkg::MAX_STEPS) begin
			r = '0;
			r.last = 1'b1;
			r.too_long = 1'b1;
			queue_cell(r);
			return;
		end
		r.cell_x = vlt_pkg::CELL_W'(pos[0]);
		r.cell_y = vlt_pkg::CELL_W'(pos[1]);
		r.cell_z = vlt_pkg::CELL_W'(pos[2]);
		r.last = (total == 0);
		r.too_long = 1'b0;
		queue_cell(r);
		emitted = 1;
		while (done[0] < span[0] || done[1] < span[1] || done[2] < span[2]) begin
			lead = -1;
			for (int i = 0; i < 3; i++) begin
				if (done[i] < span[i]) begin
					if (lead < 0)
						lead = i;
					else if ((2 * done[i] + 1) * span[lead] <
					         (2 * done[lead] + 1) * span[i])
						lead = i;
				end
			end
			for (int i = 0; i < 3; i++)
				hit[i] = done[i] < span[i] &&
					(2 * done[i] + 1) * span[lead] == (2 * done[lead] + 1) * span[i];
			for (int i = 0; i < 3; i++) begin
				if (hit[i]) begin
					done[i]++;
					pos[i] = up[i] ? pos[i] + 1 : pos[i] - 1;
				end
			end
			at_end = done[0] >= span[0] && done[1] >= span[1] && done[2] >= span[2];
			if (emitted < MAX_CELLS) begin
				r.cell_x = vlt_pkg::CELL_W'(pos[0]);
				r.cell_y = vlt_pkg::CELL_W'(pos[1]);
				r.cell_z = vlt_pkg::CELL_W'(pos[2]);
				r.last = at_end;
				r.too_long = 1'b0;
				queue_cell(r);
				emitted++;
			end
		end
	endfunction

	// Monitor: check strobed cells, predict accepted lines, watch for a hang
	always @(posedge clk) begin
		vlt_pkg::result_t want;
		if (arst_n) begin
			if (strobe) begin
				cells_checked++;
				if (predicted_cells.size() == 0) begin
					errors++;
					if (errors <= MAX_PRINTS)
						$display("%0t: unexpected cell beat, got x=%0d y=%0d z=%0d %s=%b %s=%b",
							$time, result.cell_x, result.cell_y, result.cell_z,
							"last", result.last, "long", result.too_long);
				end else begin
					want = predicted_cells.pop_front();
					if (result.cell_x !== want.cell_x || result.cell_y !== want.cell_y ||
					    result.cell_z !== want.cell_z || result.last !== want.last ||
					    result.too_long !== want.too_long) begin
						errors++;
						if (errors <= MAX_PRINTS) begin
							$display("%0t: cell mismatch, expected x=%0d y=%0d z=%0d %s=%b %s=%b",
								$time, want.cell_x, want.cell_y, want.cell_z,
								"last", want.last, "long", want.too_long);
							$display("%0t:                  got x=%0d y=%0d z=%0d %s=%b %s=%b",
								$time, result.cell_x, result.cell_y, result.cell_z,
								"last", result.last, "long", result.too_long);
						end
					end
				end
			end
			if (start && !busy) begin
				lines_sent++;
				walk_line(cmd);
			end
			if (strobe || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d cells outstanding",
					$time, QUIET_LIMIT, predicted_cells.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// One request beat; start stays high after acceptance until the next call
	task automatic send_line(input vlt_pkg::cmd_t c, input int idle_pct);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		// busy only changes at rising edges, so its value here holds at the next one
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic vlt_pkg::cmd_t line_of(input int sx, input int sy, input int sz,
		input int ex, input int ey, input int ez);
		vlt_pkg::cmd_t c;
		c.start_x = vlt_pkg::CELL_W'(sx);
		c.start_y = vlt_pkg::CELL_W'(sy);
		c.start_z = vlt_pkg::CELL_W'(sz);
		c.end_x = vlt_pkg::CELL_W'(ex);
		c.end_y = vlt_pkg::CELL_W'(ey);
		c.end_z = vlt_pkg::CELL_W'(ez);
		return c;
	endfunction

	// Random start, random direction, summed span exactly equal to budget
	function automatic vlt_pkg::cmd_t random_line(input int budget);
		int s[3];
		int d[3];
		int e[3];
		int rot;
		int hi;
		hi = (1 << vlt_pkg::CELL_W) - 1;
		d[0] = $urandom_range(0, budget);
		d[1] = $urandom_range(0, budget - d[0]);
		d[2] = budget - d[0] - d[1];
		rot = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			s[i] = $urandom_range(0, hi);
			e[i] = $urandom_range(0, 1) ? s[i] + d[(i + rot) % 3] : s[i] - d[(i + rot) % 3];
			if (e[i] > hi)
				e[i] = s[i] - d[(i + rot) % 3];
			else if (e[i] < 0)
				e[i] = s[i] + d[(i + rot) % 3];
		end
		return line_of(s[0], s[1], s[2], e[0], e[1], e[2]);
	endfunction

	task automatic test_directed();
		send_line(line_of(0, 0, 0, 0, 0, 0), 0);
		send_line(line_of(1023, 1023, 1023, 1023, 1023, 1023), 0);
		send_line(line_of(0, 500, 0, 63, 500, 0), 0);
		send_line(line_of(63, 7, 9, 0, 7, 9), 0);
		send_line(line_of(4, 0, 4, 4, 63, 4), 0);
		send_line(line_of(8, 8, 63, 8, 8, 0), 0);
		// exact corner crossings step all axes at once
		send_line(line_of(0, 0, 0, 5, 5, 5), 0);
		send_line(line_of(0, 0, 0, 21, 21, 21), 0);
		// edge tie on two axes, and a tie partway through the walk
		send_line(line_of(100, 100, 9, 103, 97, 9), 0);
		send_line(line_of(0, 0, 0, 3, 1, 0), 0);
		send_line(line_of(0, 0, 0, 2, 1, 0), 0);
		send_line(line_of(10, 20, 30, 5, 25, 30), 0);
		send_line(line_of(1023, 0, 1023, 1003, 20, 1003), 0);
		send_line(line_of(1023, 1023, 1023, 1000, 1010, 1023), 0);
		// span just over the step limit, and far apart
		send_line(line_of(0, 0, 0, 64, 0, 0), 0);
		send_line(line_of(0, 0, 0, 21, 21, 22), 0);
		send_line(line_of(0, 0, 0, 1023, 1023, 1023), 0);
		send_line(line_of(1023, 1023, 1023, 0, 0, 0), 0);
		send_line(line_of(682, 341, 1023, 341, 682, 0), 0);
		send_line(line_of(1, 2, 3, 3, 1, 2), 0);
	endtask

	task automatic test_random_lines(input int count, input int idle_pct);
		vlt_pkg::cmd_t c;
		int            pick;
		logic [63:0]   raw;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				c = random_line($urandom_range(0, 12));
			end else if (pick < 85) begin
				c = random_line($urandom_range(13, vlt_pkg::MAX_STEPS));
			end else if (pick < 92) begin
				c = random_line($urandom_range(vlt_pkg::MAX_STEPS + 1,
					vlt_pkg::MAX_STEPS + 8));
			end else begin
				raw = {$urandom, $urandom};
				c = raw[$bits(vlt_pkg::cmd_t)-1:0];
			end
			send_line(c, idle_pct);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (predicted_cells.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		lines_sent = 0;
		cells_checked = 0;
		errors = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		// receiver cannot hold results off, so the phases vary only the sender's idling
		test_random_lines(115, 0);
		test_random_lines(115, 51);
		test_random_lines(110, 0);
		test_random_lines(110, 15);
		wait_drained();

		if (predicted_cells.size() != 0) begin
			errors++;
			$display("%0t: %0d predicted cells never arrived", $time, predicted_cells.size());
		end
		$display("Walked %0d line requests (directed corners, ties, limit cases, random spans)",
			lines_sent);
		$display("Checked %0d cell beats with sender gaps of 0, 51 and 15 percent; %0d errors",
			cells_checked, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
